FILE: rtl/pccd_pkg.sv
// ----------------------------------------------------------------------------
// pccd_pkg
// Shared types and codes of the command frame deframer: header and opcode
// bytes, frame status codes, frame positions and the item structs.
// ----------------------------------------------------------------------------
package pccd_pkg;

	localparam int MAX_DATA_DEF = 16;

	// Frame bytes
	localparam logic [7:0] HEAD_FIRST   = 8'h10;
	localparam logic [7:0] HEAD_SECOND  = 8'h01;
	localparam logic [7:0] OP_BELL      = 8'h01;
	localparam logic [7:0] OP_LED       = 8'h02;
	localparam logic [7:0] OP_REQ       = 8'h03;
	localparam logic [7:0] BELL_ON_CODE = 8'h01;
	localparam logic [7:0] LED_ON_CODE  = 8'h03;

	// Frame status codes
	localparam logic [2:0] ST_BUSY   = 3'd0;
	localparam logic [2:0] ST_OK     = 3'd1;
	localparam logic [2:0] ST_HEAD   = 3'd2;
	localparam logic [2:0] ST_PARITY = 3'd3;
	localparam logic [2:0] ST_LENGTH = 3'd4;

	// Positions within a frame
	localparam int POS_HEAD1  = 0;
	localparam int POS_HEAD2  = 1;
	localparam int POS_OPCODE = 2;
	localparam int POS_LENGTH = 3;
	localparam int POS_DATA0  = 4;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic       bell_on;
		logic       led_on;
		logic       request_data;
		logic [2:0] frame_status;
	} result_item_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} stage1_t;

endpackage

FILE: rtl/pccd_stream_if.sv
// ----------------------------------------------------------------------------
// pccd_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface pccd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/pccd_in_reg.sv
// ----------------------------------------------------------------------------
// pccd_in_reg
// Input register: capture one received byte per transfer, hold it while the
// result side stalls.
// ----------------------------------------------------------------------------
module pccd_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	pccd_stream_if.sink        rx,
	output pccd_pkg::stage1_t  s1
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// Take a new byte when the stage is empty or drains this cycle
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data.rx_byte;
		end
	end

	assign s1.valid   = valid_s1;
	assign s1.rx_byte = byte_s1;

endmodule

FILE: rtl/pccd_frame_ctrl.sv
// ----------------------------------------------------------------------------
// pccd_frame_ctrl
// Frame state, parity fold, opcode action and the result register.
// ----------------------------------------------------------------------------
module pccd_frame_ctrl #(
	parameter int MAX_DATA = pccd_pkg::MAX_DATA_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pccd_pkg::stage1_t  s1,
	output logic               advance,
	pccd_stream_if.source      result
);

	localparam int         CntW   = $clog2(MAX_DATA + 5);
	localparam int         LenW   = $clog2(MAX_DATA + 1);
	localparam logic [8:0] MaxLen = 9'(MAX_DATA);

	logic [CntW-1:0] byte_count_q, byte_count_d;
	logic [LenW-1:0] frame_length_q, frame_length_d;
	logic [7:0]      opcode_q, opcode_d;
	logic [7:0]      first_data_q, first_data_d;
	logic            parity_q, parity_d;
	logic            bell_q, bell_d;
	logic            led_q, led_d;

	logic                   valid_s2;
	pccd_pkg::result_item_t res_s2;

	logic       fire;
	logic [7:0] b;
	logic       folded;
	logic [2:0] status;
	logic       req;

	assign advance = !valid_s2 || result.ready;
	assign fire    = s1.valid && advance;
	assign b       = s1.rx_byte;
	assign folded  = parity_q ^ (^b);

	always_comb begin
		byte_count_d   = byte_count_q;
		frame_length_d = frame_length_q;
		opcode_d       = opcode_q;
		first_data_d   = first_data_q;
		parity_d       = parity_q;
		bell_d         = bell_q;
		led_d          = led_q;
		status         = pccd_pkg::ST_BUSY;
		req            = 1'b0;

		if (byte_count_q == CntW'(pccd_pkg::POS_HEAD1)) begin
			if (b != pccd_pkg::HEAD_FIRST) begin
				status = pccd_pkg::ST_HEAD;
			end else begin
				parity_d     = 1'b1 ^ (^b);
				byte_count_d = CntW'(pccd_pkg::POS_HEAD2);
			end
		end else if (byte_count_q == CntW'(pccd_pkg::POS_HEAD2)) begin
			// restart without retrying this byte as a first header
			byte_count_d = CntW'(pccd_pkg::POS_HEAD1);
			if (b != pccd_pkg::HEAD_SECOND) begin
				status = pccd_pkg::ST_HEAD;
			end else begin
				parity_d     = folded;
				byte_count_d = CntW'(pccd_pkg::POS_OPCODE);
			end
		end else if (byte_count_q == CntW'(pccd_pkg::POS_OPCODE)) begin
			opcode_d     = b;
			parity_d     = folded;
			byte_count_d = CntW'(pccd_pkg::POS_LENGTH);
		end else if (byte_count_q == CntW'(pccd_pkg::POS_LENGTH)) begin
			if ({1'b0, b} > MaxLen) begin
				status       = pccd_pkg::ST_LENGTH;
				byte_count_d = CntW'(pccd_pkg::POS_HEAD1);
			end else begin
				frame_length_d = LenW'(b);
				parity_d       = folded;
				byte_count_d   = CntW'(pccd_pkg::POS_DATA0);
			end
		end else begin
			// first data byte may also be the parity byte of an empty frame
			if (byte_count_q == CntW'(pccd_pkg::POS_DATA0)) begin
				first_data_d = b;
			end
			if (byte_count_q >= CntW'(pccd_pkg::POS_DATA0) + CntW'(frame_length_q)) begin
				byte_count_d = CntW'(pccd_pkg::POS_HEAD1);
				if (b != {7'd0, parity_q}) begin
					status = pccd_pkg::ST_PARITY;
				end else begin
					status = pccd_pkg::ST_OK;
					if (opcode_q == pccd_pkg::OP_BELL) begin
						bell_d = (first_data_d == pccd_pkg::BELL_ON_CODE);
					end else if (opcode_q == pccd_pkg::OP_LED) begin
						led_d = (first_data_d == pccd_pkg::LED_ON_CODE);
					end else if (opcode_q == pccd_pkg::OP_REQ) begin
						req = 1'b1;
					end
				end
			end else begin
				parity_d     = folded;
				byte_count_d = byte_count_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			frame_length_q <= '0;
			opcode_q       <= '0;
			first_data_q   <= '0;
			parity_q       <= 1'b1;
			bell_q         <= 1'b0;
			led_q          <= 1'b0;
		end else if (fire) begin
			byte_count_q   <= byte_count_d;
			frame_length_q <= frame_length_d;
			opcode_q       <= opcode_d;
			first_data_q   <= first_data_d;
			parity_q       <= parity_d;
			bell_q         <= bell_d;
			led_q          <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2.bell_on      <= bell_d;
			res_s2.led_on       <= led_d;
			res_s2.request_data <= req;
			res_s2.frame_status <= status;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

endmodule

FILE: rtl/parity_checked_command_deframer_core.sv
// ----------------------------------------------------------------------------
// parity_checked_command_deframer_core
// Command frame deframer: header 0x10 0x01, opcode, length, data bytes and
// a parity byte; drives bell and LED flags and a data request pulse.
//
//   channel  | dir | payload                                      | transfer
//   ---------+-----+----------------------------------------------+-----------
//   rx       | in  | rx_byte[7:0]                                 | one byte
//   result   | out | bell_on, led_on, request_data, frame_status  | one result
//
// One result per received byte; the rx transfer reaches result valid through
// the input register, then the result register. A new byte is taken every
// cycle unless stalled; the input register and the result register form a
// two-stage pipeline that stalls once both registers are full and result
// is held. arst_n clears the frame position, the flags and both valid bits;
// the expected parity starts at one.
// ----------------------------------------------------------------------------
module parity_checked_command_deframer_core #(
	parameter int MAX_DATA = pccd_pkg::MAX_DATA_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pccd_stream_if.sink   rx,
	pccd_stream_if.source result
);

	// Stage 1 contents and the stall line from the result side
	pccd_pkg::stage1_t s1;
	logic              advance;

	// Capture bytes; hold while the result register is full and not taken
	pccd_in_reg u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.rx     (rx),
		.s1     (s1)
	);

	// Advance the frame state and register one result per byte
	pccd_frame_ctrl #(
		.MAX_DATA(MAX_DATA)
	) u_frame_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.s1     (s1),
		.advance(advance),
		.result (result)
	);

`ifndef SYNTHESIS
	// A captured byte always moves into stage 1
	a_rx_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		rx.valid && rx.ready |=> s1.valid)
		else $error("accepted byte not held in input register");

	// A byte leaving stage 1 always yields a result
	a_s1_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1.valid && advance |=> result.valid)
		else $error("byte lost between input and result register");

	// Data request pulses only on an accepted frame
	a_req_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.request_data
		|-> result.data.frame_status == pccd_pkg::ST_OK)
		else $error("data request without accepted frame");

	// Status stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.data.frame_status <= pccd_pkg::ST_LENGTH)
		else $error("frame status out of range");
`endif

endmodule
